FILE: rtl/fcwc_pkg.sv
package fcwc_pkg;

    localparam int PAGE_BYTES_DEF = 512;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [9:0] PAGE_MAX = 10'h3FF;
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    // APB register index, taken from paddr[2]
    localparam logic REG_FLASH_BASE = 1'b0;
    localparam logic REG_LAST_PAGE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CMD_UNLOCK  = 3'd0,
        CMD_ERASE   = 3'd1,
        CMD_PROGRAM = 3'd2,
        CMD_LOCK    = 3'd3,
        CMD_REJECT  = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] flash_address;
        logic [31:0] program_word;
        logic        last;
    } result_t;

    // up to two results pushed per processed transaction
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: rtl/fcwc_result_fifo.sv
module fcwc_result_fifo
    import fcwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  push_t       push,
    output logic        room_two,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     head
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   head_reg, head_next;
    logic [FIFO_PTR_W-1:0]   tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [FIFO_PTR_W-1:0]   tail_plus_one;
    logic                    pop;

    assign m_valid       = (count_reg != '0);
    assign pop           = m_valid && m_ready;
    assign head          = entry_reg[head_reg];
    assign room_two      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign tail_plus_one = tail_reg + FIFO_PTR_W'(1);

    always_comb begin
        head_next  = pop ? head_reg + FIFO_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + FIFO_PTR_W'(push.count);
        count_next = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[tail_plus_one] <= push.second;
        end
    end

endmodule

FILE: rtl/flash_continuous_write_combiner_top.sv
// Channel   Direction  Ports                                    Transaction
// s_        in         s_valid s_ready s_mode s_start_page        one command item
//                      s_data_byte
// m_        out        m_valid m_ready m_command                 one flash command
//                      m_flash_address m_program_word m_last
// apb       in         psel penable pwrite paddr pwdata          register access
//                      prdata pready
//
// An accepted item is held in the input register, decoded in one pass against
// the page/word/byte counters, and pushes zero to two results into a four-entry
// result queue; results leave the queue head one per cycle while m_ready is high.
// Sustained rate is one item per cycle while m_ready is high and each item yields
// at most one result; items yielding two are limited by the single output port.
// The input register stalls whenever the queue has fewer than two free entries.
// Reset (aresetn low, synchronous) clears counters, queue, base; last page = max.
module flash_continuous_write_combiner_top
    import fcwc_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [9:0]  s_start_page,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_command,
    output logic [31:0] m_flash_address,
    output logic [31:0] m_program_word,
    output logic        m_last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS  = PAGE_BYTES / 4;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    // configuration
    logic [31:0] flash_base_reg;
    logic [9:0]  last_page_reg;
    logic        cfg_write;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [9:0]  in_page_reg;
    logic [7:0]  in_byte_reg;

    // sequencer state
    logic [9:0]        page_reg, page_next;
    logic              past_end_reg, past_end_next;
    logic              erased_reg, erased_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [WORD_W-1:0] word_idx_reg, word_idx_next;
    logic [31:0]       asm_reg, asm_next;

    logic        fire;
    logic        room_two;
    push_t       push;
    result_t     head;
    logic [31:0] page_start;
    logic [31:0] word_addr;
    logic [31:0] filled_word;
    logic [31:0] padded_word;
    result_t     res_erase, res_program, res_pad, res_lock;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_FLASH_BASE: prdata = flash_base_reg;
            REG_LAST_PAGE:  prdata = {22'd0, last_page_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_base_reg <= '0;
            last_page_reg  <= PAGE_MAX;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FLASH_BASE) begin
                flash_base_reg <= pwdata;
            end else begin
                last_page_reg <= pwdata[9:0];
            end
        end
    end

    // ---------------- input register ----------------
    assign fire    = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_page_reg <= s_start_page;
            in_byte_reg <= s_data_byte;
        end
    end

    // ---------------- decode pass ----------------
    assign page_start = flash_base_reg + 32'(page_reg) * 32'(PAGE_BYTES);
    assign word_addr  = page_start + 32'({word_idx_reg, 2'b00});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            filled_word[8*i +: 8] = (byte_idx_reg == 2'(i)) ? in_byte_reg : asm_reg[8*i +: 8];
            padded_word[8*i +: 8] = (2'(i) >= byte_idx_reg) ? PAD_BYTE : asm_reg[8*i +: 8];
        end
    end

    always_comb begin
        res_erase   = '{command: CMD_ERASE, flash_address: page_start,
                        program_word: '0, last: 1'b0};
        res_program = '{command: CMD_PROGRAM, flash_address: word_addr,
                        program_word: filled_word, last: 1'b1};
        res_pad     = '{command: CMD_PROGRAM, flash_address: word_addr,
                        program_word: padded_word, last: 1'b0};
        res_lock    = '{command: CMD_LOCK, flash_address: '0,
                        program_word: '0, last: 1'b1};
    end

    always_comb begin
        page_next     = page_reg;
        past_end_next = past_end_reg;
        erased_next   = erased_reg;
        byte_idx_next = byte_idx_reg;
        word_idx_next = word_idx_reg;
        asm_next      = asm_reg;
        push          = '0;

        if (fire) begin
            unique case (in_mode_reg)
                MODE_START: begin
                    page_next     = in_page_reg;
                    past_end_next = 1'b0;
                    push.count    = 2'd1;
                    push.first    = '{command: CMD_UNLOCK, flash_address: '0,
                                      program_word: '0, last: 1'b1};
                end
                MODE_DATA: begin
                    if (past_end_reg || (page_reg > last_page_reg)) begin
                        push.count = 2'd1;
                        push.first = '{command: CMD_REJECT, flash_address: '0,
                                       program_word: '0, last: 1'b1};
                    end else begin
                        erased_next   = 1'b1;
                        asm_next      = filled_word;
                        byte_idx_next = byte_idx_reg + 2'd1;
                        if (!erased_reg) begin
                            push.count = 2'd1;
                            push.first = res_erase;
                            push.first.last = (byte_idx_reg != 2'd3);
                            if (byte_idx_reg == 2'd3) begin
                                push.count  = 2'd2;
                                push.second = res_program;
                            end
                        end else if (byte_idx_reg == 2'd3) begin
                            push.count = 2'd1;
                            push.first = res_program;
                        end
                        // word complete: advance word, and page at end of page
                        if (byte_idx_reg == 2'd3) begin
                            word_idx_next = word_idx_reg + WORD_W'(1);
                            if (word_idx_reg == WORD_W'(WORDS - 1)) begin
                                word_idx_next = '0;
                                erased_next   = 1'b0;
                                if (page_reg == PAGE_MAX) begin
                                    page_next     = '0;
                                    past_end_next = 1'b1;
                                end else begin
                                    page_next = page_reg + 10'd1;
                                end
                            end
                        end
                    end
                end
                MODE_STOP: begin
                    if (erased_reg) begin
                        byte_idx_next = '0;
                        word_idx_next = '0;
                        erased_next   = 1'b0;
                        if (byte_idx_reg != 2'd0) begin
                            asm_next    = padded_word;
                            push.count  = 2'd2;
                            push.first  = res_pad;
                            push.second = res_lock;
                        end else begin
                            push.count = 2'd1;
                            push.first = res_lock;
                        end
                    end
                end
                default: begin
                    // unused mode: drop the transaction
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg     <= '0;
            past_end_reg <= 1'b0;
            erased_reg   <= 1'b0;
            byte_idx_reg <= '0;
            word_idx_reg <= '0;
            asm_reg      <= '0;
        end else begin
            page_reg     <= page_next;
            past_end_reg <= past_end_next;
            erased_reg   <= erased_next;
            byte_idx_reg <= byte_idx_next;
            word_idx_reg <= word_idx_next;
            asm_reg      <= asm_next;
        end
    end

    // ---------------- result queue ----------------
    fcwc_result_fifo u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room_two (room_two),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign m_command       = head.command;
    assign m_flash_address = head.flash_address;
    assign m_program_word  = head.program_word;
    assign m_last          = head.last;

endmodule
